// File: hdl/voxel_box_sphere_fill_unit_assert.svh
// assertion macros for the voxel fill unit
// clock and reset are taken from the scope of the use
`ifndef VOXEL_BOX_SPHERE_FILL_UNIT_ASSERT_SVH
`define VOXEL_BOX_SPHERE_FILL_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define VBSF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define VBSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/vbsf_pkg.sv
package vbsf_pkg;

   // default store extents
   localparam int MAX_X_DEF = 16;
   localparam int MAX_Y_DEF = 64;
   localparam int MAX_Z_DEF = 16;

   // field widths
   localparam int KIND_W     = 2;
   localparam int COORD_W    = 8;
   localparam int RADIUS_W   = 12;
   localparam int BLOCK_W    = 8;
   localparam int COUNT_W    = 15;
   localparam int SIZE_X_W   = 5;
   localparam int SIZE_Y_W   = 7;
   localparam int SIZE_Z_W   = 5;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 2;

   // distance arithmetic, sized for the largest allowed extents
   localparam int DIFF_W  = 10;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int R2_W    = 2 * RADIUS_W;
   localparam int FRAC2_W = 8;
   localparam int CMP_W   = SUM_W + FRAC2_W;

   // size register reset values
   localparam logic [SIZE_X_W-1:0] SIZE_X_RESET = 5'd16;
   localparam logic [SIZE_Y_W-1:0] SIZE_Y_RESET = 7'd64;
   localparam logic [SIZE_Z_W-1:0] SIZE_Z_RESET = 5'd16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_BOX    = 2'd0,
      KIND_SPHERE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] x_a;
      logic signed [COORD_W-1:0] y_a;
      logic signed [COORD_W-1:0] z_a;
      logic signed [COORD_W-1:0] x_b;
      logic signed [COORD_W-1:0] y_b;
      logic signed [COORD_W-1:0] z_b;
      logic [RADIUS_W-1:0]       radius;
      logic [BLOCK_W-1:0]        block_value;
   } req_payload_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] read_value;
      logic               inside_res;
      logic [COUNT_W-1:0] written_count;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic step;
      logic read_en;
      logic load_result;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic extent_empty;
      logic iter_last;
   } status_type;

endpackage

// File: hdl/vbsf_if.sv
// request channel
interface vbsf_req_if import vbsf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [COORD_W-1:0] x_a;
   logic signed [COORD_W-1:0] y_a;
   logic signed [COORD_W-1:0] z_a;
   logic signed [COORD_W-1:0] x_b;
   logic signed [COORD_W-1:0] y_b;
   logic signed [COORD_W-1:0] z_b;
   logic [RADIUS_W-1:0]       radius;
   logic [BLOCK_W-1:0]        block_value;

   modport source (output valid, kind, x_a, y_a, z_a, x_b, y_b, z_b, radius, block_value,
                   input ready);
   modport sink (input valid, kind, x_a, y_a, z_a, x_b, y_b, z_b, radius, block_value,
                 output ready);
endinterface

// response channel
interface vbsf_rsp_if import vbsf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] read_value;
   logic               inside_res;
   logic [COUNT_W-1:0] written_count;

   modport source (output valid, read_value, inside_res, written_count, input ready);
   modport sink (input valid, read_value, inside_res, written_count, output ready);
endinterface

// File: hdl/vbsf_ctrl.sv
module vbsf_ctrl import vbsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  kind_type   req_kind,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // state and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_kind)
                  KIND_BOX, KIND_SPHERE: state_in = ST_FILL;
                  KIND_READ:             state_in = ST_READ;
                  default:               state_in = ST_DONE;
               endcase
            end
         end
         ST_FILL: begin
            if (status.extent_empty) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.step = 1'b1;
               if (status.iter_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/vbsf_dp.sv
module vbsf_dp import vbsf_pkg::*; #(
   parameter int MAX_X = MAX_X_DEF,
   parameter int MAX_Y = MAX_Y_DEF,
   parameter int MAX_Z = MAX_Z_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  req_payload_type       req,
   input  cmd_type               cmd,
   output status_type            status,
   output rsp_payload_type       rsp
);

   localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CX_W   = $clog2(MAX_X + 1);
   localparam int CY_W   = $clog2(MAX_Y + 1);
   localparam int CZ_W   = $clog2(MAX_Z + 1);

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CX_W-1:0] x,
                                                   input logic [CY_W-1:0] y,
                                                   input logic [CZ_W-1:0] z);
      cell_addr = ADDR_W'((32'(x) * 32'(MAX_Y) + 32'(y)) * 32'(MAX_Z) + 32'(z));
   endfunction

   // size registers
   logic [SIZE_X_W-1:0] size_x_ff;
   logic [SIZE_Y_W-1:0] size_y_ff;
   logic [SIZE_Z_W-1:0] size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_X_RESET;
         size_y_ff <= SIZE_Y_RESET;
         size_z_ff <= SIZE_Z_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_write_data[SIZE_X_W-1:0];
            CSR_SIZE_Y: size_y_ff <= csr_write_data[SIZE_Y_W-1:0];
            CSR_SIZE_Z: size_z_ff <= csr_write_data[SIZE_Z_W-1:0];
            default: ;
         endcase
      end
   end

   // extents clipped to the store
   logic [CX_W-1:0] ex_in;
   logic [CY_W-1:0] ey_in;
   logic [CZ_W-1:0] ez_in;

   always_comb begin
      ex_in = (32'(size_x_ff) > MAX_X) ? CX_W'(MAX_X) : CX_W'(size_x_ff);
      ey_in = (32'(size_y_ff) > MAX_Y) ? CY_W'(MAX_Y) : CY_W'(size_y_ff);
      ez_in = (32'(size_z_ff) > MAX_Z) ? CZ_W'(MAX_Z) : CZ_W'(size_z_ff);
   end

   // request latched on accept
   kind_type                  kind_ff;
   logic signed [COORD_W-1:0] xa_ff, ya_ff, za_ff;
   logic signed [COORD_W-1:0] lx_ff, hx_ff, ly_ff, hy_ff, lz_ff, hz_ff;
   logic [R2_W-1:0]           r2_ff;
   logic [BLOCK_W-1:0]        block_ff;
   logic [CX_W-1:0]           ex_ff;
   logic [CY_W-1:0]           ey_ff;
   logic [CZ_W-1:0]           ez_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= kind_type'(req.kind);
         xa_ff    <= req.x_a;
         ya_ff    <= req.y_a;
         za_ff    <= req.z_a;
         lx_ff    <= (req.x_a < req.x_b) ? req.x_a : req.x_b;
         hx_ff    <= (req.x_a < req.x_b) ? req.x_b : req.x_a;
         ly_ff    <= (req.y_a < req.y_b) ? req.y_a : req.y_b;
         hy_ff    <= (req.y_a < req.y_b) ? req.y_b : req.y_a;
         lz_ff    <= (req.z_a < req.z_b) ? req.z_a : req.z_b;
         hz_ff    <= (req.z_a < req.z_b) ? req.z_b : req.z_a;
         r2_ff    <= R2_W'(req.radius) * R2_W'(req.radius);
         block_ff <= req.block_value;
         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         ez_ff    <= ez_in;
      end
   end

   // voxel walk counters, z fastest
   logic [CX_W-1:0] cx_ff;
   logic [CY_W-1:0] cy_ff;
   logic [CZ_W-1:0] cz_ff;
   logic            cx_last, cy_last, cz_last;

   assign cx_last = (cx_ff == ex_ff - CX_W'(1));
   assign cy_last = (cy_ff == ey_ff - CY_W'(1));
   assign cz_last = (cz_ff == ez_ff - CZ_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
      end else if (cmd.step) begin
         if (cz_last) begin
            cz_ff <= '0;
            if (cy_last) begin
               cy_ff <= '0;
               cx_ff <= cx_ff + CX_W'(1);
            end else begin
               cy_ff <= cy_ff + CY_W'(1);
            end
         end else begin
            cz_ff <= cz_ff + CZ_W'(1);
         end
      end
   end

   assign status.extent_empty = (ex_ff == '0) || (ey_ff == '0) || (ez_ff == '0);
   assign status.iter_last    = cx_last && cy_last && cz_last;

   // first stage: offsets squared, box test, address
   logic signed [DIFF_W-1:0] px, py, pz, dx, dy, dz;
   logic signed [SQ_W-1:0]   sqx_in, sqy_in, sqz_in;
   logic                     box_in;

   always_comb begin
      px     = DIFF_W'(cx_ff);
      py     = DIFF_W'(cy_ff);
      pz     = DIFF_W'(cz_ff);
      dx     = px - DIFF_W'(xa_ff);
      dy     = py - DIFF_W'(ya_ff);
      dz     = pz - DIFF_W'(za_ff);
      sqx_in = dx * dx;
      sqy_in = dy * dy;
      sqz_in = dz * dz;
      box_in = (px >= DIFF_W'(lx_ff)) && (px <= DIFF_W'(hx_ff)) &&
               (py >= DIFF_W'(ly_ff)) && (py <= DIFF_W'(hy_ff)) &&
               (pz >= DIFF_W'(lz_ff)) && (pz <= DIFF_W'(hz_ff));
   end

   logic              p1_valid_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic              box_ff;
   logic [ADDR_W-1:0] p1_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         sqz_ff     <= sqz_in;
         box_ff     <= box_in;
         p1_addr_ff <= cell_addr(cx_ff, cy_ff, cz_ff);
      end
   end

   // second stage: sphere test, write and count
   logic [SUM_W-1:0] dist2;
   logic             hit;
   logic             fill_we;

   always_comb begin
      dist2 = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
      if (kind_ff == KIND_SPHERE) begin
         hit = {dist2, FRAC2_W'(0)} < CMP_W'(r2_ff);
      end else begin
         hit = box_ff;
      end
      fill_we = p1_valid_ff && hit;
   end

   logic [COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         count_ff <= '0;
      end else if (fill_we && (count_ff != {COUNT_W{1'b1}})) begin
         count_ff <= count_ff + COUNT_W'(1);
      end
   end

   // clearing pass address
   logic [ADDR_W-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
      end
   end

   assign status.clear_last = (clear_addr_ff == ADDR_W'(DEPTH - 1));

   // read position test
   logic              in_chunk;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      in_chunk = !xa_ff[COORD_W-1] && !ya_ff[COORD_W-1] && !za_ff[COORD_W-1] &&
                 (DIFF_W'(xa_ff) < DIFF_W'(ex_ff)) &&
                 (DIFF_W'(ya_ff) < DIFF_W'(ey_ff)) &&
                 (DIFF_W'(za_ff) < DIFF_W'(ez_ff));
      rd_addr = in_chunk ? cell_addr(CX_W'(xa_ff), CY_W'(ya_ff), CZ_W'(za_ff)) : '0;
   end

   // voxel store
   logic [BLOCK_W-1:0] store_mem [DEPTH];
   logic [BLOCK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         store_mem[clear_addr_ff] <= '0;
      end else if (fill_we) begin
         store_mem[p1_addr_ff] <= block_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp.read_value    <= (kind_ff == KIND_READ && in_chunk) ? rd_data_ff : '0;
         rsp.inside_res    <= (kind_ff == KIND_READ) && in_chunk;
         rsp.written_count <= count_ff;
      end
   end

endmodule

// File: hdl/voxel_box_sphere_fill_unit.sv
// fill: response valid after the walk over all N voxels, N = clipped extent product
// (one voxel visited per cycle, two-stage test and write pipeline); empty extent: no walk
// read: the store is read, then the response loaded; unused kind: no store access
// one request at a time: the next is taken once the response is loaded, even while it waits
// after reset the voxel store is zeroed, one entry per cycle, all MAX_X*MAX_Y*MAX_Z entries
// (16384 by default); no request is taken meanwhile, size registers are writable
module voxel_box_sphere_fill_unit import vbsf_pkg::*; #(
   parameter int MAX_X = MAX_X_DEF,
   parameter int MAX_Y = MAX_Y_DEF,
   parameter int MAX_Z = MAX_Z_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   vbsf_req_if.sink              req_if,
   vbsf_rsp_if.source            rsp_if,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

`include "voxel_box_sphere_fill_unit_assert.svh"

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;
   logic            req_taken;
   logic            rsp_slot_free;

   // request payload gathered
   always_comb begin
      req_payload.kind        = req_if.kind;
      req_payload.x_a         = req_if.x_a;
      req_payload.y_a         = req_if.y_a;
      req_payload.z_a         = req_if.z_a;
      req_payload.x_b         = req_if.x_b;
      req_payload.y_b         = req_if.y_b;
      req_payload.z_b         = req_if.z_b;
      req_payload.radius      = req_if.radius;
      req_payload.block_value = req_if.block_value;
   end

   vbsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (kind_type'(req_if.kind)),
      .req_ready (req_ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   vbsf_dp #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req            (req_payload),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp_payload)
   );

   // channel outputs
   assign req_if.ready         = req_ready;
   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.read_value    = rsp_payload.read_value;
   assign rsp_if.inside_res    = rsp_payload.inside_res;
   assign rsp_if.written_count = rsp_payload.written_count;

   // checks
   assign req_taken     = req_if.valid && req_ready;
   assign rsp_slot_free = !rsp_valid || rsp_if.ready;

   `VBSF_ASSERT_NOW(a_load_slot_free, cmd.load_result, rsp_slot_free, "response lost")
   `VBSF_ASSERT_NEXT(a_one_request, req_taken, !req_ready, "request taken while busy")
   `VBSF_ASSERT_NOW(a_clear_only, cmd.clear_step, !(req_ready || cmd.step), "busy in clear")

endmodule

// File: tb/voxel_box_sphere_fill_unit_tb.sv
`timescale 1ns / 1ps

module voxel_box_sphere_fill_unit_tb;
   import vbsf_pkg::*;

   localparam int STORE_CELLS      = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
   localparam int CYCLE_LIMIT      = 5_000_000;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 4;
   localparam int END_CYCLES       = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   logic            req_valid = 1'b0;
   req_payload_type req_data = '0;
   logic            rsp_ready = 1'b0;

   vbsf_req_if req_bus ();
   vbsf_rsp_if rsp_bus ();

   assign req_bus.valid       = req_valid;
   assign req_bus.kind        = req_data.kind;
   assign req_bus.x_a         = req_data.x_a;
   assign req_bus.y_a         = req_data.y_a;
   assign req_bus.z_a         = req_data.z_a;
   assign req_bus.x_b         = req_data.x_b;
   assign req_bus.y_b         = req_data.y_b;
   assign req_bus.z_b         = req_data.z_b;
   assign req_bus.radius      = req_data.radius;
   assign req_bus.block_value = req_data.block_value;
   assign rsp_bus.ready       = rsp_ready;

   voxel_box_sphere_fill_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // commands waiting to be offered and results still owed by the block
   req_payload_type queued_cmds[$];
   rsp_payload_type predicted_results[$];

   // shadow of the voxel store and the size registers
   logic [BLOCK_W-1:0]  voxel_image [STORE_CELLS] = '{default: '0};
   logic [SIZE_X_W-1:0] size_x_cfg = SIZE_X_RESET;
   logic [SIZE_Y_W-1:0] size_y_cfg = SIZE_Y_RESET;
   logic [SIZE_Z_W-1:0] size_z_cfg = SIZE_Z_RESET;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned cmds_taken = 0;
   int unsigned results_checked = 0;
   int unsigned voxels_written = 0;
   int unsigned read_hits = 0;
   int unsigned size_settings = 0;

   // sender burst shaping
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   // receiver stall pattern and the one long hold-off
   int unsigned ready_mode = 0;
   int unsigned ready_span_left = 0;
   int unsigned ready_tick = 0;
   int unsigned rsp_hold_left = 0;
   bit          long_hold_armed = 1'b0;
   bit          long_hold_done = 1'b0;

   // apply one command to the shadow store, return the result it should give
   function automatic rsp_payload_type apply_voxel_cmd(req_payload_type cmd);
      rsp_payload_type res;
      int ex, ey, ez;
      int xa, ya, za, xb, yb, zb;
      int lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
      longint dist2, rad2;
      int unsigned hits;
      bit hit;
      res = '0;
      hits = 0;
      ex = (size_x_cfg > MAX_X_DEF) ? MAX_X_DEF : int'(size_x_cfg);
      ey = (size_y_cfg > MAX_Y_DEF) ? MAX_Y_DEF : int'(size_y_cfg);
      ez = (size_z_cfg > MAX_Z_DEF) ? MAX_Z_DEF : int'(size_z_cfg);
      xa = $signed(cmd.x_a);
      ya = $signed(cmd.y_a);
      za = $signed(cmd.z_a);
      xb = $signed(cmd.x_b);
      yb = $signed(cmd.y_b);
      zb = $signed(cmd.z_b);
      if (cmd.kind == KIND_BOX || cmd.kind == KIND_SPHERE) begin
         // corners may come in either order
         lo_x = (xa < xb) ? xa : xb;
         hi_x = (xa < xb) ? xb : xa;
         lo_y = (ya < yb) ? ya : yb;
         hi_y = (ya < yb) ? yb : ya;
         lo_z = (za < zb) ? za : zb;
         hi_z = (za < zb) ? zb : za;
         rad2 = longint'(cmd.radius) * longint'(cmd.radius);
         for (int x = 0; x < ex; x++) begin
            for (int y = 0; y < ey; y++) begin
               for (int z = 0; z < ez; z++) begin
                  if (cmd.kind == KIND_BOX) begin
                     hit = x >= lo_x && x <= hi_x && y >= lo_y && y <= hi_y &&
                           z >= lo_z && z <= hi_z;
                  end else begin
                     // radius carries 4 fraction bits, so distance squared scales by 256
                     dist2 = (x - xa) * (x - xa) + (y - ya) * (y - ya) + (z - za) * (z - za);
                     hit = dist2 * 256 < rad2;
                  end
                  if (hit) begin
                     voxel_image[(x * MAX_Y_DEF + y) * MAX_Z_DEF + z] = cmd.block_value;
                     if (hits < 32767) hits++;
                  end
               end
            end
         end
         res.written_count = COUNT_W'(hits);
      end else if (cmd.kind == KIND_READ) begin
         if (xa >= 0 && xa < ex && ya >= 0 && ya < ey && za >= 0 && za < ez) begin
            res.inside_res = 1'b1;
            res.read_value = voxel_image[(xa * MAX_Y_DEF + ya) * MAX_Z_DEF + za];
         end
      end
      return res;
   endfunction

   function automatic req_payload_type make_cmd(kind_type k, int xa, int ya, int za,
                                                int xb, int yb, int zb,
                                                int unsigned rad, int unsigned blk);
      req_payload_type c;
      c.kind        = k;
      c.x_a         = COORD_W'(xa);
      c.y_a         = COORD_W'(ya);
      c.z_a         = COORD_W'(za);
      c.x_b         = COORD_W'(xb);
      c.y_b         = COORD_W'(yb);
      c.z_b         = COORD_W'(zb);
      c.radius      = RADIUS_W'(rad);
      c.block_value = BLOCK_W'(blk);
      return c;
   endfunction

   // mostly near the chunk, sometimes anywhere in the signed byte range
   function automatic logic signed [COORD_W-1:0] pick_coord(int extent);
      if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, 255));
      return COORD_W'($urandom_range(0, extent + 5) - 3);
   endfunction

   function automatic req_payload_type random_cmd(int ex, int ey, int ez);
      req_payload_type c;
      int unsigned pick;
      int unsigned reach;
      pick = $urandom_range(0, 19);
      reach = ex;
      if (ey > reach) reach = ey;
      if (ez > reach) reach = ez;
      if (pick < 7 || pick == 19) c.kind = KIND_READ;
      else if (pick < 12) c.kind = KIND_BOX;
      else if (pick < 18) c.kind = KIND_SPHERE;
      else c.kind = KIND_NONE;
      c.x_a = pick_coord(ex);
      c.y_a = pick_coord(ey);
      c.z_a = pick_coord(ez);
      c.x_b = pick_coord(ex);
      c.y_b = pick_coord(ey);
      c.z_b = pick_coord(ez);
      c.radius = ($urandom_range(0, 3) == 0) ? RADIUS_W'($urandom_range(0, 4095))
                                             : RADIUS_W'($urandom_range(0, 16 * (reach + 2)));
      c.block_value = BLOCK_W'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic check_field(input string name, input logic [15:0] expv,
                              input logic [15:0] actv);
      if (actv !== expv) begin
         $error("%s: expected %0d, got %0d", name, expv, actv);
         error_count++;
      end
   endtask

   // block is idle once nothing is queued, offered or owed
   task automatic wait_until_drained();
      do @(negedge clock);
      while (queued_cmds.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   task automatic write_size_regs(input int sx, input int sy, input int sz);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SIZE_X;
      csr_write_data <= CSR_DATA_W'(sx);
      @(posedge clock);
      csr_index      <= CSR_SIZE_Y;
      csr_write_data <= CSR_DATA_W'(sy);
      @(posedge clock);
      csr_index      <= CSR_SIZE_Z;
      csr_write_data <= CSR_DATA_W'(sz);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      size_settings++;
   endtask

   task automatic run_phase(input int sx, input int sy, input int sz, input int n_cmds,
                            input bit with_long_hold);
      int ex, ey, ez;
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_size_regs(sx, sy, sz);
      ex = (sx > MAX_X_DEF) ? MAX_X_DEF : sx;
      ey = (sy > MAX_Y_DEF) ? MAX_Y_DEF : sy;
      ez = (sz > MAX_Z_DEF) ? MAX_Z_DEF : sz;
      @(negedge clock);
      if (with_long_hold) long_hold_armed = 1'b1;
      repeat (n_cmds) queued_cmds.push_back(random_cmd(ex, ey, ez));
   endtask

   // request driver: bursts with random gaps, prediction on every accepted request
   always @(posedge clock) begin
      rsp_payload_type predicted;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SIZE_X: size_x_cfg = csr_write_data[SIZE_X_W-1:0];
            CSR_SIZE_Y: size_y_cfg = csr_write_data[SIZE_Y_W-1:0];
            CSR_SIZE_Z: size_z_cfg = csr_write_data[SIZE_Z_W-1:0];
            default: ;
         endcase
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_bus.ready) begin
            predicted = apply_voxel_cmd(req_data);
            predicted_results.push_back(predicted);
            cmds_taken++;
            voxels_written += 32'(predicted.written_count);
            if (predicted.inside_res) read_hits++;
         end
         if (!req_valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (queued_cmds.size() != 0) begin
               req_data  <= queued_cmds.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started once when armed
   always @(posedge clock) begin
      if (long_hold_armed && !long_hold_done) begin
         rsp_hold_left  <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      bit ready_pick;
      if (!reset) begin
         if (rsp_bus.valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("response with nothing outstanding: read_value %0d written_count %0d",
                      rsp_bus.read_value, rsp_bus.written_count);
               error_count++;
            end else begin
               check_field("read_value", 16'(predicted_results[0].read_value),
                           16'(rsp_bus.read_value));
               check_field("inside_res", 16'(predicted_results[0].inside_res),
                           16'(rsp_bus.inside_res));
               check_field("written_count", 16'(predicted_results[0].written_count),
                           16'(rsp_bus.written_count));
               void'(predicted_results.pop_front());
               results_checked++;
            end
         end
         if (ready_span_left == 0) begin
            ready_mode      <= $urandom_range(0, 3);
            ready_span_left <= $urandom_range(20, 80);
         end else begin
            ready_span_left <= ready_span_left - 1;
         end
         ready_tick <= ready_tick + 1;
         case (ready_mode)
            0: ready_pick = 1'b1;
            1: ready_pick = 1'($urandom_range(0, 1));
            2: ready_pick = ($urandom_range(0, 3) == 0);
            default: ready_pick = (ready_tick[1:0] != 2'd3);
         endcase
         rsp_ready <= (rsp_hold_left == 0) && ready_pick;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("voxel_box_sphere_fill_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // size registers accept writes while the store is being cleared
      write_size_regs(MAX_X_DEF, MAX_Y_DEF, MAX_Z_DEF);
      @(negedge clock);

      // directed: freshly cleared store, field extremes, every kind
      queued_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, 15, 63, 15, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, 16, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, -1, 5, 5, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, 127, 127, 127, 127, 127, 127, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, -128, -128, -128, -128, -128, -128,
                                     4095, 255));
      // whole store, corners reversed
      queued_cmds.push_back(make_cmd(KIND_BOX, 127, 127, 127, -128, -128, -128, 0, 255));
      queued_cmds.push_back(make_cmd(KIND_READ, 15, 63, 15, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_BOX, 5, 10, 3, 2, 4, 7, 0, 8'h5a));
      queued_cmds.push_back(make_cmd(KIND_READ, 3, 6, 5, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, 6, 6, 5, 0, 0, 0, 0, 0));
      // zero radius writes nothing
      queued_cmds.push_back(make_cmd(KIND_SPHERE, 8, 32, 8, 0, 0, 0, 0, 0));
      // radius of exactly three voxels: the surface itself stays untouched
      queued_cmds.push_back(make_cmd(KIND_SPHERE, 8, 32, 8, 0, 0, 0, 48, 8'h80));
      queued_cmds.push_back(make_cmd(KIND_READ, 11, 32, 8, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, 10, 32, 8, 0, 0, 0, 0, 0));
      // largest radius from far outside, at both extreme centres
      queued_cmds.push_back(make_cmd(KIND_SPHERE, -128, -128, -128, 0, 0, 0, 4095, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_SPHERE, 127, 127, 127, 0, 0, 0, 4095, 8'h33));
      // box entirely off the chunk
      queued_cmds.push_back(make_cmd(KIND_BOX, -5, -5, -5, -1, 70, 20, 0, 8'h11));
      // unused kind leaves everything alone
      queued_cmds.push_back(make_cmd(KIND_NONE, 3, 3, 3, 9, 9, 9, 4095, 255));
      queued_cmds.push_back(make_cmd(KIND_READ, 8, 40, 8, 0, 0, 0, 0, 0));
      queued_cmds.push_back(make_cmd(KIND_READ, 15, 0, 15, 0, 0, 0, 0, 0));

      // random requests over a range of chunk sizes, empty and oversized among them
      run_phase(4, 8, 4, 8, 1'b0);
      run_phase(0, 8, 4, 5, 1'b0);
      run_phase(3, 0, 5, 4, 1'b0);
      run_phase(2, 3, 0, 4, 1'b0);
      run_phase(1, 1, 1, 6, 1'b0);
      run_phase(5, 7, 3, 14, 1'b1);
      run_phase(31, 127, 31, 4, 1'b0);
      run_phase(8, 16, 8, 8, 1'b0);
      run_phase(16, 2, 1, 8, 1'b0);
      run_phase(1, 64, 1, 8, 1'b0);
      run_phase(1, 1, 16, 8, 1'b0);
      run_phase(6, 12, 6, 6, 1'b0);

      wait_until_drained();
      repeat (END_CYCLES) @(posedge clock);

      $display("%0d requests over %0d chunk size settings, %0d results checked",
               cmds_taken, size_settings, results_checked);
      $display("%0d voxels filled, %0d reads landed inside the chunk",
               voxels_written, read_hits);
      if (predicted_results.size() != 0) begin
         $error("%0d results never arrived", predicted_results.size());
      end
      if (error_count == 0 && predicted_results.size() == 0) begin
         $display("voxel_box_sphere_fill_unit_tb: done, clean");
      end else begin
         $display("voxel_box_sphere_fill_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
